// ===== design/bbpe_pkg.sv =====
package bbpe_pkg;

	localparam int COORD_BITS = 32;
	localparam int FRAC_BITS  = 16;
	localparam int PARAM_BITS = FRAC_BITS + 1;
	localparam int WT_BITS    = FRAC_BITS + 2;
	localparam int PROD_BITS  = 2 * WT_BITS;
	localparam int ACC_BITS   = COORD_BITS + 3 * FRAC_BITS + 8;
	localparam int GRID_DEPTH = 16;
	localparam int NUM_TERMS  = 16;
	localparam int QUEUE_DEPTH = 2;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EVAL = 1'b1;

	typedef logic [WT_BITS-1:0] wt_t;
	typedef logic [PARAM_BITS-1:0] par_t;

	typedef struct packed {
		par_t u;
		par_t v;
	} eval_req_t;

	typedef struct packed {
		wt_t w0;
		wt_t w1;
		wt_t w2;
		wt_t w3;
	} wset_t;

endpackage

// ===== design/bicubic_bezier_patch_eval.sv =====
// Bicubic Bezier patch evaluator, Q16.16 coordinates, Q1.16 parameters.
// Input channel (valid/ready): opcode 0 loads one control point into the
// 4x4 grid at row_index/col_index and gives no result; opcode 1 evaluates
// the surface at param_u/param_v and gives one result on the output channel.
// A front part takes each transfer: loads write the grid at once, evaluates
// go into a two-entry queue. The back part pops one evaluate at a time,
// runs two weight units, each with one shared multiplier and a squarer
// for t*t, hands the weights over, then walks the 16 grid terms through a
// two-stage multiply/accumulate and registers the rounded, saturated
// point. It pops the next evaluate only once the receiver has taken the
// result; further evaluates wait in the queue meanwhile.
// A load waits until no evaluate is queued or running.
// Reset clears the grid to zero and empties the queue.
// When the receiver stalls, hold the result; up to two further evaluates
// still transfer into the queue.
module bicubic_bezier_patch_eval
	import bbpe_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic opcode,
	input  logic [1:0] row_index,
	input  logic [1:0] col_index,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	input  logic signed [COORD_BITS-1:0] point_z,
	input  logic [PARAM_BITS-1:0] param_u,
	input  logic [PARAM_BITS-1:0] param_v,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [COORD_BITS-1:0] surf_x,
	output logic signed [COORD_BITS-1:0] surf_y,
	output logic signed [COORD_BITS-1:0] surf_z,
	output logic saturated
);

	logic ld_we, q_valid, q_pop, grid_busy;
	logic [3:0] ld_addr;
	logic [3*COORD_BITS-1:0] ld_data;
	eval_req_t q_head;

	// front: classify and queue
	bbpe_front u_front (.clk, .arst_n, .valid(in_valid), .ready(in_ready), .opcode,
		.row_index, .col_index, .point_x, .point_y, .point_z, .param_u, .param_v,
		.grid_busy, .ld_we, .ld_addr, .ld_data, .q_valid, .q_pop, .q_head);

	// back: weights, tensor sum, output register
	bbpe_back u_back (.clk, .arst_n, .ld_we, .ld_addr, .ld_data, .q_valid, .q_pop,
		.q_head, .busy(grid_busy), .out_valid, .out_ready, .surf_x, .surf_y, .surf_z,
		.saturated);

endmodule

// ===== design/bbpe_weights.sv =====
module bbpe_weights
	import bbpe_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  par_t t_in,
	output logic busy,
	output logic done,
	output wset_t wts
);

	localparam int MW = WT_BITS;
	localparam int PW = 2 * WT_BITS;
	localparam logic [MW-1:0] ONE  = MW'(1) << FRAC_BITS;
	localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

	typedef enum logic [2:0] {
		W_IDLE, W_TS, W_SQ, W_B0, W_B1, W_B2, W_B3
	} wstate_t;

	wstate_t state_q;
	logic [MW-1:0] t_q, s_q, ts_q, ss_q, tt_q, t_clip;
	logic [MW-1:0] ma, mb;
	logic [PW-1:0] prod, rnd, tsq;

	always_comb begin
		ma = t_q;
		mb = s_q;
		unique case (state_q)
			W_TS: begin ma = t_q; mb = s_q; end
			W_SQ: begin ma = s_q; mb = s_q; end
			W_B0: begin ma = ss_q; mb = s_q; end
			W_B1: begin ma = ts_q * MW'(3); mb = s_q; end
			W_B2: begin ma = ts_q * MW'(3); mb = t_q; end
			W_B3: begin ma = tt_q; mb = t_q; end
			default: begin ma = t_q; mb = s_q; end
		endcase
		prod = ma * mb;
		rnd  = (prod + HALF) >> FRAC_BITS;
		tsq  = t_q * t_q;
	end

	// parameters above one count as one
	assign t_clip = (t_in > PARAM_BITS'(ONE)) ? ONE : MW'(t_in);

	assign busy = (state_q != W_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_IDLE;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				W_IDLE: if (start) begin
					t_q     <= t_clip;
					s_q     <= ONE - t_clip;
					state_q <= W_TS;
				end
				W_TS: begin ts_q <= MW'(rnd); state_q <= W_SQ; end
				W_SQ: begin
					ss_q    <= MW'(rnd);
					tt_q    <= MW'((tsq + HALF) >> FRAC_BITS);
					state_q <= W_B0;
				end
				W_B0: begin wts.w0 <= WT_BITS'(rnd); state_q <= W_B1; end
				W_B1: begin wts.w1 <= WT_BITS'(rnd); state_q <= W_B2; end
				W_B2: begin wts.w2 <= WT_BITS'(rnd); state_q <= W_B3; end
				W_B3: begin
					wts.w3  <= WT_BITS'(rnd);
					done    <= 1'b1;
					state_q <= W_IDLE;
				end
				default: state_q <= W_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("weights done while busy");
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("weights did not start");
	assert property (@(posedge clk) disable iff (!arst_n) done |-> $past(busy))
		else $error("spurious done");

endmodule

// ===== design/bbpe_front.sv =====
module bbpe_front
	import bbpe_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic valid,
	output logic ready,
	input  logic opcode,
	input  logic [1:0] row_index,
	input  logic [1:0] col_index,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	input  logic signed [COORD_BITS-1:0] point_z,
	input  par_t param_u,
	input  par_t param_v,
	input  logic grid_busy,
	output logic ld_we,
	output logic [3:0] ld_addr,
	output logic [3*COORD_BITS-1:0] ld_data,
	output logic q_valid,
	input  logic q_pop,
	output eval_req_t q_head
);

	eval_req_t q_mem_q [QUEUE_DEPTH];
	logic q_wr_q, q_rd_q;
	logic [1:0] q_cnt_q;
	logic push;

	// loads must not overtake a queued evaluate that still reads the grid
	assign ready = (opcode == OP_EVAL) ? (q_cnt_q != 2'(QUEUE_DEPTH))
	                                   : (q_cnt_q == 2'd0 && !grid_busy);
	assign push    = valid && ready && (opcode == OP_EVAL);
	assign ld_we   = valid && ready && (opcode == OP_LOAD);
	assign ld_addr = {row_index, col_index};
	assign ld_data = {point_x, point_y, point_z};
	assign q_valid = (q_cnt_q != 2'd0);
	assign q_head  = q_mem_q[q_rd_q];

	always_ff @(posedge clk) begin
		if (push) q_mem_q[q_wr_q] <= '{u: param_u, v: param_v};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_wr_q  <= 1'b0;
			q_rd_q  <= 1'b0;
			q_cnt_q <= 2'd0;
		end else begin
			if (push) q_wr_q <= ~q_wr_q;
			if (q_pop) q_rd_q <= ~q_rd_q;
			q_cnt_q <= q_cnt_q + 2'(push) - 2'(q_pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_valid)
		else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n) q_cnt_q <= 2'(QUEUE_DEPTH))
		else $error("queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n) ld_we |-> !q_valid)
		else $error("load overtook evaluate");

endmodule

// ===== design/bbpe_back.sv =====
module bbpe_back
	import bbpe_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic ld_we,
	input  logic [3:0] ld_addr,
	input  logic [3*COORD_BITS-1:0] ld_data,
	input  logic q_valid,
	output logic q_pop,
	input  eval_req_t q_head,
	output logic busy,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [COORD_BITS-1:0] surf_x,
	output logic signed [COORD_BITS-1:0] surf_y,
	output logic signed [COORD_BITS-1:0] surf_z,
	output logic saturated
);

	typedef enum logic [1:0] {B_IDLE, B_WTS, B_ACC, B_OUT} bstate_t;

	localparam logic signed [ACC_BITS-1:0] HALF2 = ACC_BITS'(1) << (2*FRAC_BITS - 1);

	bstate_t state_q;
	logic signed [COORD_BITS-1:0] gx_q [GRID_DEPTH];
	logic signed [COORD_BITS-1:0] gy_q [GRID_DEPTH];
	logic signed [COORD_BITS-1:0] gz_q [GRID_DEPTH];
	logic [4:0] k_q;
	logic wu_busy, wv_busy, wu_done, wv_done, got_u_q, got_v_q, w_start;
	wset_t wu, wv;
	wt_t wu_sel, wv_sel;
	logic [PROD_BITS-1:0] wprod_s1;
	logic signed [COORD_BITS-1:0] px_s1, py_s1, pz_s1;
	logic p_valid_s1;
	logic signed [ACC_BITS-1:0] ax_q, ay_q, az_q;
	logic [COORD_BITS:0] cx, cy, cz;

	function automatic logic signed [ACC_BITS-1:0] term(
		input logic [PROD_BITS-1:0] w, input logic signed [COORD_BITS-1:0] p);
		term = $signed({1'b0, w}) * p;
	endfunction

	function automatic logic [COORD_BITS:0] clampc(input logic signed [ACC_BITS-1:0] a);
		logic signed [ACC_BITS-1:0] r;
		logic [ACC_BITS-COORD_BITS:0] top;
		begin
			r   = (a + HALF2) >>> (2*FRAC_BITS);
			top = r[ACC_BITS-1:COORD_BITS-1];
			if (top == '0 || top == '1) clampc = {1'b0, r[COORD_BITS-1:0]};
			else if (r[ACC_BITS-1]) clampc = {1'b1, 1'b1, {(COORD_BITS-1){1'b0}}};
			else clampc = {1'b1, 1'b0, {(COORD_BITS-1){1'b1}}};
		end
	endfunction

	assign w_start = (state_q == B_IDLE) && q_valid;
	assign q_pop   = w_start;
	assign busy    = (state_q != B_IDLE);

	bbpe_weights u_wu (.clk, .arst_n, .start(w_start), .t_in(q_head.u),
		.busy(wu_busy), .done(wu_done), .wts(wu));
	bbpe_weights u_wv (.clk, .arst_n, .start(w_start), .t_in(q_head.v),
		.busy(wv_busy), .done(wv_done), .wts(wv));

	always_comb begin
		unique case (k_q[3:2])
			2'd0: wu_sel = wu.w0;
			2'd1: wu_sel = wu.w1;
			2'd2: wu_sel = wu.w2;
			default: wu_sel = wu.w3;
		endcase
		unique case (k_q[1:0])
			2'd0: wv_sel = wv.w0;
			2'd1: wv_sel = wv.w1;
			2'd2: wv_sel = wv.w2;
			default: wv_sel = wv.w3;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < GRID_DEPTH; i++) begin
				gx_q[i] <= '0; gy_q[i] <= '0; gz_q[i] <= '0;
			end
		end else if (ld_we) begin
			gx_q[ld_addr] <= ld_data[3*COORD_BITS-1:2*COORD_BITS];
			gy_q[ld_addr] <= ld_data[2*COORD_BITS-1:COORD_BITS];
			gz_q[ld_addr] <= ld_data[COORD_BITS-1:0];
		end
	end

	assign cx = clampc(ax_q);
	assign cy = clampc(ay_q);
	assign cz = clampc(az_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_IDLE;
			out_valid  <= 1'b0;
			p_valid_s1 <= 1'b0;
			got_u_q    <= 1'b0;
			got_v_q    <= 1'b0;
			k_q        <= '0;
		end else begin
			p_valid_s1 <= 1'b0;
			unique case (state_q)
				B_IDLE: if (w_start) begin
					state_q <= B_WTS;
					got_u_q <= 1'b0;
					got_v_q <= 1'b0;
				end
				B_WTS: begin
					if (wu_done) got_u_q <= 1'b1;
					if (wv_done) got_v_q <= 1'b1;
					if ((got_u_q || wu_done) && (got_v_q || wv_done)) begin
						state_q <= B_ACC;
						k_q     <= '0;
						ax_q <= '0; ay_q <= '0; az_q <= '0;
					end
				end
				B_ACC: begin
					// stage 1: weight product and grid read; stage 2: accumulate
					if (k_q < 5'(NUM_TERMS)) begin
						wprod_s1   <= wu_sel * wv_sel;
						px_s1      <= gx_q[k_q[3:0]];
						py_s1      <= gy_q[k_q[3:0]];
						pz_s1      <= gz_q[k_q[3:0]];
						p_valid_s1 <= 1'b1;
						k_q        <= k_q + 5'd1;
					end
					if (p_valid_s1) begin
						ax_q <= ax_q + term(wprod_s1, px_s1);
						ay_q <= ay_q + term(wprod_s1, py_s1);
						az_q <= az_q + term(wprod_s1, pz_s1);
					end
					if (k_q == 5'(NUM_TERMS) && !p_valid_s1) state_q <= B_OUT;
				end
				B_OUT: begin
					if (!out_valid) begin
						surf_x    <= cx[COORD_BITS-1:0];
						surf_y    <= cy[COORD_BITS-1:0];
						surf_z    <= cz[COORD_BITS-1:0];
						saturated <= cx[COORD_BITS] | cy[COORD_BITS] | cz[COORD_BITS];
						out_valid <= 1'b1;
					end else if (out_ready) begin
						out_valid <= 1'b0;
						state_q   <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> state_q == B_OUT)
		else $error("result outside output state");
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> !$past(busy) || $past(state_q == B_OUT))
		else $error("pop while evaluating");
	assert property (@(posedge clk) disable iff (!arst_n) ld_we |-> !busy)
		else $error("grid written during evaluate");
	assert property (@(posedge clk) disable iff (!arst_n) w_start |-> !wu_busy && !wv_busy)
		else $error("weights restarted while busy");

endmodule

// ===== dv/bicubic_bezier_patch_eval_tb.sv =====
module bicubic_bezier_patch_eval_tb;
	import bbpe_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [PARAM_BITS-1:0] ONE_FX = PARAM_BITS'(1) << FRAC_BITS;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic signed [COORD_BITS-1:0] z;
		logic sat;
	} surf_pt_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic opcode;
	logic [1:0] row_index;
	logic [1:0] col_index;
	logic signed [COORD_BITS-1:0] point_x;
	logic signed [COORD_BITS-1:0] point_y;
	logic signed [COORD_BITS-1:0] point_z;
	logic [PARAM_BITS-1:0] param_u;
	logic [PARAM_BITS-1:0] param_v;
	logic out_valid;
	logic out_ready;
	logic signed [COORD_BITS-1:0] surf_x;
	logic signed [COORD_BITS-1:0] surf_y;
	logic signed [COORD_BITS-1:0] surf_z;
	logic saturated;

	// Shadow copy of the control grid, index row*4+col.
	logic signed [COORD_BITS-1:0] shadow_x [GRID_DEPTH];
	logic signed [COORD_BITS-1:0] shadow_y [GRID_DEPTH];
	logic signed [COORD_BITS-1:0] shadow_z [GRID_DEPTH];

	surf_pt_t pending_pts [$];
	int errors;
	int cycles;
	bit long_stalls;

	bicubic_bezier_patch_eval dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Abort on a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(20, 60);
		if ($urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, 3);
	endfunction

	function automatic logic [63:0] round_fx(logic [63:0] a);
		return (a + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
	endfunction

	// Cubic Bernstein weights, each with FRAC_BITS fractional bits.
	function automatic void bernstein(input logic [PARAM_BITS-1:0] p,
			output logic [63:0] w [4]);
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] ts;
		t = (p > ONE_FX) ? 64'(ONE_FX) : 64'(p);
		s = 64'(ONE_FX) - t;
		ts = round_fx(t * s);
		w[0] = round_fx(round_fx(s * s) * s);
		w[1] = round_fx(3 * ts * s);
		w[2] = round_fx(3 * ts * t);
		w[3] = round_fx(round_fx(t * t) * t);
	endfunction

	function automatic logic signed [COORD_BITS-1:0] blend_coord(
			input logic signed [COORD_BITS-1:0] g [GRID_DEPTH],
			input logic [63:0] wu [4], input logic [63:0] wv [4], inout logic sat);
		logic signed [127:0] acc;
		logic signed [127:0] q;
		logic signed [127:0] cmax;
		logic signed [127:0] cmin;
		acc = 0;
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++)
				acc += $signed({1'b0, 64'(wu[i] * wv[j])}) * 128'(g[i * 4 + j]);
		acc += 128'sd1 <<< (2 * FRAC_BITS - 1);
		q = acc >>> (2 * FRAC_BITS);
		cmax = (128'sd1 <<< (COORD_BITS - 1)) - 1;
		cmin = -(128'sd1 <<< (COORD_BITS - 1));
		if (q > cmax) begin
			sat = 1'b1;
			q = cmax;
		end else if (q < cmin) begin
			sat = 1'b1;
			q = cmin;
		end
		return q[COORD_BITS-1:0];
	endfunction

	function automatic surf_pt_t predict_surface(logic [PARAM_BITS-1:0] u,
			logic [PARAM_BITS-1:0] v);
		logic [63:0] wu [4];
		logic [63:0] wv [4];
		surf_pt_t r;
		logic sat;
		sat = 1'b0;
		bernstein(u, wu);
		bernstein(v, wv);
		r.x = blend_coord(shadow_x, wu, wv, sat);
		r.y = blend_coord(shadow_y, wu, wv, sat);
		r.z = blend_coord(shadow_z, wu, wv, sat);
		r.sat = sat;
		return r;
	endfunction

	// Drive one item and hold it until the transfer; update the model on transfer.
	// Drop valid at the first falling edge only when a gap follows.
	task automatic send_item(logic op, logic [1:0] r, logic [1:0] c,
			logic [31:0] px, logic [31:0] py, logic [31:0] pz,
			logic [PARAM_BITS-1:0] u, logic [PARAM_BITS-1:0] v);
		int g;
		g = gap_len();
		@(negedge clk);
		if (g != 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		row_index <= r;
		col_index <= c;
		point_x <= px;
		point_y <= py;
		point_z <= pz;
		param_u <= u;
		param_v <= v;
		do @(posedge clk); while (!in_ready);
		if (op == OP_LOAD) begin
			shadow_x[{r, c}] = px;
			shadow_y[{r, c}] = py;
			shadow_z[{r, c}] = pz;
		end else begin
			pending_pts.insert(pending_pts.size(), predict_surface(u, v));
		end
	endtask

	task automatic load_point(logic [1:0] r, logic [1:0] c,
			logic [31:0] px, logic [31:0] py, logic [31:0] pz);
		send_item(OP_LOAD, r, c, px, py, pz, PARAM_BITS'($urandom),
				PARAM_BITS'($urandom));
	endtask

	task automatic eval_at(logic [PARAM_BITS-1:0] u, logic [PARAM_BITS-1:0] v);
		send_item(OP_EVAL, 2'($urandom), 2'($urandom), $urandom, $urandom, $urandom,
				u, v);
	endtask

	function automatic logic [PARAM_BITS-1:0] rand_param();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return ONE_FX;
			2: return PARAM_BITS'($urandom_range(ONE_FX + 1, (1 << PARAM_BITS) - 1));
			default: return PARAM_BITS'($urandom_range(0, ONE_FX));
		endcase
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return $urandom_range(0, 32'h0003_ffff) - 32'h0002_0000;
			default: return $urandom;
		endcase
	endfunction

	// Drop valid, then hold until every result is back.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_pts.size() != 0)
			@(negedge clk);
	endtask

	// Receiver side: random stalls.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready <= long_stalls ? ($urandom_range(0, 3) == 0)
					: ($urandom_range(0, 3) != 0);
		end
	end

	// Compare each result with the oldest prediction.
	always @(posedge clk) begin
		surf_pt_t exp_pt;
		if (arst_n && out_valid && out_ready) begin
			if (pending_pts.size() == 0) begin
				$display("%0t: unexpected result x=%h y=%h z=%h", $time, surf_x, surf_y,
						surf_z);
				errors++;
			end else begin
				exp_pt = pending_pts.pop_front();
				if (surf_x !== exp_pt.x) begin
					$display("%0t: surf_x exp %h got %h", $time, exp_pt.x, surf_x);
					errors++;
				end
				if (surf_y !== exp_pt.y) begin
					$display("%0t: surf_y exp %h got %h", $time, exp_pt.y, surf_y);
					errors++;
				end
				if (surf_z !== exp_pt.z) begin
					$display("%0t: surf_z exp %h got %h", $time, exp_pt.z, surf_z);
					errors++;
				end
				if (saturated !== exp_pt.sat) begin
					$display("%0t: saturated exp %b got %b", $time, exp_pt.sat, saturated);
					errors++;
				end
			end
		end
	end

	// Zero grid straight after reset, corners of u,v and an inner point.
	task automatic test_reset_grid();
		eval_at(0, 0);
		eval_at(ONE_FX, ONE_FX);
		eval_at(ONE_FX / 2, ONE_FX / 3);
	endtask

	// Extreme corners and a flat patch; params above one clamp to one.
	task automatic test_directed();
		load_point(0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000);
		load_point(3, 3, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_0000);
		load_point(0, 3, 32'h0002_0000, 32'h0, 32'h1234_5678);
		load_point(3, 0, 32'hfffe_0000, 32'h0, 32'hedcb_a988);
		eval_at(0, 0);
		eval_at(ONE_FX, ONE_FX);
		eval_at(ONE_FX, 0);
		eval_at(0, ONE_FX);
		eval_at('1, '1);
		eval_at(ONE_FX + PARAM_BITS'(1), 1);
		eval_at(ONE_FX / 2, ONE_FX / 2);
		// Every point at the extremes (x and z max, y min): the sum of weights may overshoot and saturate.
		for (int k = 0; k < GRID_DEPTH; k++)
			load_point(k[3:2], k[1:0], 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
		eval_at(ONE_FX / 2, ONE_FX / 3);
		eval_at(12345, 54321);
	endtask

	// Mostly evaluations over a patch rebuilt now and then.
	task automatic test_random(int n_items);
		for (int n = 0; n < n_items; n++) begin
			if ($urandom_range(0, 3) == 0)
				load_point(2'($urandom), 2'($urandom), rand_coord(), rand_coord(),
						rand_coord());
			else
				eval_at(rand_param(), rand_param());
			if (n == n_items / 2) begin
				// Hold off until every result is back.
				drain();
				long_stalls = 1'b1;
			end
			if (n == n_items * 3 / 4)
				long_stalls = 1'b0;
		end
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		long_stalls = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_LOAD;
		row_index = '0;
		col_index = '0;
		point_x = '0;
		point_y = '0;
		point_z = '0;
		param_u = '0;
		param_v = '0;
		for (int k = 0; k < GRID_DEPTH; k++) begin
			shadow_x[k] = '0;
			shadow_y[k] = '0;
			shadow_z[k] = '0;
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_reset_grid();
		test_directed();
		test_random(850);
		drain();
		repeat (60) @(negedge clk);
		if (errors == 0 && pending_pts.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
